/* design/assert_macros.svh */
// Shared assertion shorthands; clk and rst must be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/cpm_pkg.sv */
package cpm_pkg;

  localparam int BUCKETS    = 64;
  localparam int SLOT_W     = $clog2(BUCKETS);
  localparam int PAGE_W     = 48;
  localparam int LOAD_LIMIT = BUCKETS * 3 / 4;
  localparam int CNT_W      = $clog2(LOAD_LIMIT);

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_MODIFY = 2'd1,
    OP_COMMIT = 2'd2,
    OP_CLOSE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_FILE    = 3'd1,
    ST_CLAIMED = 3'd2,
    ST_RANGE   = 3'd3,
    ST_FULL    = 3'd4,
    ST_ENTRY   = 3'd5,
    ST_DONE    = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE_RD,
    S_PROBE_CMP,
    S_WALK,
    S_WALK_DATA,
    S_EMIT
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [PAGE_W-1:0] req_page;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [PAGE_W-1:0] page_out;
    logic              last;
  } out_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } push_t;

endpackage

/* design/cow_page_map_linear_probe.sv */
// Get/modify: a miss ends at the first empty slot, a hit at the compare that matches; each
//   occupied slot probed costs a RAM read plus compare (47 at most); next accept follows S_EMIT.
// Commit: WALK, WALK_DATA, EMIT per valid entry, WALK per empty slot; close, empty commit: EMIT.
// One transaction in flight; the page RAM read port sets the per-probe cost.
// Reset (synchronous, rst high): empty table, count 0, file_pages 0, output empty;
//   valid bits are flops cleared directly by reset, so there is no clearing pass.
module cow_page_map_linear_probe
  import cpm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              cfg_we,
  input  logic [PAGE_W-1:0] cfg_data
);

  // Page count of the mapped file; the user must write it only while no transaction is open (not enforced).
  logic [PAGE_W-1:0] file_pages;

  // Result handoff from the probe/commit sequencer to the output register.
  push_t push;
  logic  push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_pages <= '0;
    end else if (cfg_we) begin
      file_pages <= cfg_data;
    end
  end

  // Sequencer: valid bits and entry count in flops, page numbers in a
  // RAM with a registered read; walks probe chains and commit sweeps.
  cpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .file_pages(file_pages),
    .push      (push),
    .push_ready(push_ready)
  );

  // Output register: holds one result so the sequencer can return to idle
  // and accept the next transaction while the result waits downstream.
  cpm_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_ready(push_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* design/cpm_ram.sv */
module cpm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/cpm_out_reg.sv */
`include "assert_macros.svh"

module cpm_out_reg
  import cpm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  push_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  assign push_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_ready) begin
      out_valid <= push.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ready && push.valid) begin
      out_data <= push.data;
    end
  end

  // a held result stays put until taken
  `ASSERT_NEXT(a_hold_stable, out_valid && !out_ready, out_valid && $stable(out_data), "held result dropped or changed")

endmodule

/* design/cpm_ctrl.sv */
`include "assert_macros.svh"

module cpm_ctrl
  import cpm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  in_t               in_data,
  output logic              in_ready,
  input  logic [PAGE_W-1:0] file_pages,
  output push_t             push,
  input  logic              push_ready
);

  state_t             state, state_next;
  op_t                op_q, op_next;
  logic [PAGE_W-1:0]  pg, pg_next;
  logic [SLOT_W-1:0]  idx, idx_next;
  logic [SLOT_W-1:0]  probes, probes_next;
  logic [CNT_W-1:0]   emitted, emitted_next;
  logic [CNT_W-1:0]   entry_count, count_next;
  logic [BUCKETS-1:0] slot_valid, valid_next;
  out_t               res, res_next;

  logic               ram_we, ram_re;
  logic [PAGE_W-1:0]  rdata;
  logic               out_of_range;
  logic [CNT_W-1:0]   emitted_inc;

  cpm_ram #(
    .WIDTH(PAGE_W),
    .DEPTH(BUCKETS)
  ) u_page_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx),
    .wdata(pg),
    .re   (ram_re),
    .raddr(idx),
    .rdata(rdata)
  );

  assign out_of_range = (pg >= file_pages);
  assign emitted_inc  = emitted + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      slot_valid  <= '0;
    end else begin
      state       <= state_next;
      entry_count <= count_next;
      slot_valid  <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q    <= op_next;
    pg      <= pg_next;
    idx     <= idx_next;
    probes  <= probes_next;
    emitted <= emitted_next;
    res     <= res_next;
  end

  always_comb begin
    state_next   = state;
    op_next      = op_q;
    pg_next      = pg;
    idx_next     = idx;
    probes_next  = probes;
    emitted_next = emitted;
    count_next   = entry_count;
    valid_next   = slot_valid;
    res_next     = res;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    in_ready     = 1'b0;
    push.valid   = 1'b0;
    push.data    = res;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_next      = in_data.op;
          pg_next      = in_data.req_page;
          idx_next     = in_data.req_page[SLOT_W-1:0];
          probes_next  = '0;
          emitted_next = '0;
          res_next     = '{status: ST_DONE, slot: '0, page_out: '0, last: 1'b1};
          case (in_data.op)
            OP_GET, OP_MODIFY: begin
              state_next = S_PROBE_RD;
            end
            OP_COMMIT: begin
              if (entry_count == '0) begin
                state_next = S_EMIT;
              end else begin
                idx_next   = '0;
                state_next = S_WALK;
              end
            end
            OP_CLOSE: begin
              valid_next = '0;
              count_next = '0;
              state_next = S_EMIT;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      // empty slot ends the probe without a RAM read; a claim writes the page there
      S_PROBE_RD: begin
        if (!slot_valid[idx]) begin
          res_next.page_out = pg;
          res_next.last     = 1'b1;
          res_next.slot     = '0;
          if (out_of_range) begin
            res_next.status = ST_RANGE;
          end else if (op_q == OP_GET) begin
            res_next.status = ST_FILE;
          end else if (entry_count < CNT_W'(LOAD_LIMIT - 1)) begin
            ram_we          = 1'b1;
            valid_next[idx] = 1'b1;
            count_next      = entry_count + CNT_W'(1);
            res_next.status = ST_CLAIMED;
            res_next.slot   = idx;
          end else begin
            res_next.status = ST_FULL;
          end
          state_next = S_EMIT;
        end else begin
          ram_re     = 1'b1;
          state_next = S_PROBE_CMP;
        end
      end

      S_PROBE_CMP: begin
        res_next.page_out = pg;
        res_next.last     = 1'b1;
        if (rdata == pg) begin
          res_next.status = ST_HIT;
          res_next.slot   = idx;
          state_next      = S_EMIT;
        end else if (probes == SLOT_W'(BUCKETS - 1)) begin
          // wrapped the whole table: no empty slot
          res_next.slot   = '0;
          res_next.status = out_of_range ? ST_RANGE :
                            (op_q == OP_GET) ? ST_FILE : ST_FULL;
          state_next      = S_EMIT;
        end else begin
          idx_next    = idx + SLOT_W'(1);
          probes_next = probes + SLOT_W'(1);
          state_next  = S_PROBE_RD;
        end
      end

      S_WALK: begin
        if (slot_valid[idx]) begin
          ram_re     = 1'b1;
          state_next = S_WALK_DATA;
        end else begin
          idx_next = idx + SLOT_W'(1);
        end
      end

      S_WALK_DATA: begin
        res_next.status   = ST_ENTRY;
        res_next.slot     = idx;
        res_next.page_out = rdata;
        res_next.last     = (emitted_inc == entry_count);
        state_next        = S_EMIT;
      end

      S_EMIT: begin
        push.valid = 1'b1;
        if (push_ready) begin
          if (res.last) begin
            if (op_q == OP_COMMIT) begin
              valid_next = '0;
              count_next = '0;
            end
            state_next = S_IDLE;
          end else begin
            emitted_next = emitted_inc;
            idx_next     = idx + SLOT_W'(1);
            state_next   = S_WALK;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `ASSERT_ALWAYS(a_count_tracks_valid, $countones(slot_valid) == int'(entry_count), "count mismatch")
  `ASSERT_ALWAYS(a_load_bound, entry_count < CNT_W'(LOAD_LIMIT), "load limit exceeded")
  `ASSERT_IMPL(a_claim_marked, state == S_EMIT && res.status == ST_CLAIMED, slot_valid[res.slot], "claimed slot not valid")

endmodule
